FILE: rtl/spq_pkg.sv
// Package for the stable priority queue: transaction structs, status codes,
// controller/datapath command and status groups. No dependencies.
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRI_W     = 8;
	localparam int TAG_W     = 16;
	localparam int OCC_W     = 5;
	localparam int STATUS_W  = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// what the response register is loaded with
	localparam logic [1:0] RES_DONE  = 2'd0;
	localparam logic [1:0] RES_FULL  = 2'd1;
	localparam logic [1:0] RES_EMPTY = 2'd2;
	localparam logic [1:0] RES_POP   = 2'd3;

	typedef struct packed {
		logic             operation;
		logic [PRI_W-1:0] entry_priority;
		logic [TAG_W-1:0] entry_tag;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    front_tag;
		logic [PRI_W-1:0]    front_priority;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [TAG_W-1:0] tag;
	} slot_t;

	typedef struct packed {
		logic       load;      // latch request, k = count
		logic       rd_front;  // read slot at head
		logic       rd_prev;   // read logical slot k-1
		logic       shift;     // move read slot into logical slot k, k--
		logic       place;     // write new entry at logical slot k, count++
		logic       pop;       // advance head, count--
		logic       rsp_load;  // load response register
		logic [1:0] rsp_kind;
	} cmd_t;

	typedef struct packed {
		logic is_insert;
		logic full;
		logic empty;
		logic k_zero;
		logic prev_lower;      // slot read is of strictly lower priority
		logic rsp_free;
	} sts_t;

endpackage

FILE: rtl/spq_ctrl.sv
// Controller state machine for the stable priority queue.
// Depends on spq_pkg for the command and status groups.
module spq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  spq_pkg::sts_t  sts,
	output spq_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECIDE  = 3'd1;
	localparam logic [2:0] S_INS_RD  = 3'd2;
	localparam logic [2:0] S_INS_CMP = 3'd3;
	localparam logic [2:0] S_RM_WAIT = 3'd4;
	localparam logic [2:0] S_RESP    = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] res_q, res_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_insert) begin
					if (sts.full) begin
						res_d   = spq_pkg::RES_FULL;
						state_d = S_RESP;
					end else begin
						state_d = S_INS_RD;
					end
				end else begin
					if (sts.empty) begin
						res_d   = spq_pkg::RES_EMPTY;
						state_d = S_RESP;
					end else begin
						cmd.rd_front = 1'b1;
						state_d      = S_RM_WAIT;
					end
				end
			end
			S_INS_RD: begin
				if (sts.k_zero) begin
					cmd.place = 1'b1;
					res_d     = spq_pkg::RES_DONE;
					state_d   = S_RESP;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.prev_lower) begin
					cmd.shift = 1'b1;
					state_d   = S_INS_RD;
				end else begin
					cmd.place = 1'b1;
					res_d     = spq_pkg::RES_DONE;
					state_d   = S_RESP;
				end
			end
			S_RM_WAIT: begin
				cmd.pop = 1'b1;
				res_d   = spq_pkg::RES_POP;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					cmd.rsp_kind = res_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= spq_pkg::RES_DONE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

FILE: rtl/spq_dp.sv
// Datapath for the stable priority queue: circular slot memory, head and
// count registers, scan index, compare and response register. Uses spq_pkg.
module spq_dp #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::req_t  req,
	input  spq_pkg::cmd_t  cmd,
	output spq_pkg::sts_t  sts,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output spq_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	spq_pkg::slot_t mem [DEPTH];

	logic [AW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             k_q;
	logic                      op_q;
	logic [spq_pkg::PRI_W-1:0] pri_q;
	logic [spq_pkg::TAG_W-1:0] tag_q;
	spq_pkg::slot_t            rd_q;
	logic                      rsp_valid_q;
	spq_pkg::rsp_t             rsp_q;

	logic [AW-1:0] waddr, prev_addr, raddr, head_nxt;

	// logical slot index to memory address, wrapping once past the end
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
	                                       input logic [CW-1:0] idx);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(idx);
		if (sum >= (CW+1)'(DEPTH))
			sum = sum - (CW+1)'(DEPTH);
		return sum[AW-1:0];
	endfunction

	assign waddr     = phys(head_q, k_q);
	assign prev_addr = phys(head_q, k_q - CW'(1));
	assign raddr     = cmd.rd_front ? head_q : prev_addr;
	assign head_nxt  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.shift)
			mem[waddr] <= rd_q;
		else if (cmd.place)
			mem[waddr] <= '{pri: pri_q, tag: tag_q};
		if (cmd.rd_front || cmd.rd_prev)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.operation;
			pri_q <= req.entry_priority;
			tag_q <= req.entry_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.load)
				k_q <= count_q;
			else if (cmd.shift)
				k_q <= k_q - CW'(1);
			if (cmd.place)
				count_q <= count_q + CW'(1);
			else if (cmd.pop)
				count_q <= count_q - CW'(1);
			if (cmd.pop)
				head_q <= head_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.rsp_load)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.occupancy      <= spq_pkg::OCC_W'(count_q);
			rsp_q.front_tag      <= (cmd.rsp_kind == spq_pkg::RES_POP) ? rd_q.tag : '0;
			rsp_q.front_priority <= (cmd.rsp_kind == spq_pkg::RES_POP) ? rd_q.pri : '0;
			unique case (cmd.rsp_kind)
				spq_pkg::RES_DONE:  rsp_q.status <= spq_pkg::ST_DONE;
				spq_pkg::RES_FULL:  rsp_q.status <= spq_pkg::ST_FULL;
				spq_pkg::RES_EMPTY: rsp_q.status <= spq_pkg::ST_EMPTY;
				spq_pkg::RES_POP:   rsp_q.status <= spq_pkg::ST_DONE;
				default: rsp_q.status <= spq_pkg::ST_DONE;
			endcase
		end
	end

	assign sts.is_insert  = (op_q == spq_pkg::OP_INSERT);
	assign sts.full       = (count_q == CW'(DEPTH));
	assign sts.empty      = (count_q == '0);
	assign sts.k_zero     = (k_q == '0);
	assign sts.prev_lower = (rd_q.pri < pri_q);
	assign sts.rsp_free   = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/stable_priority_queue.sv
// Stable priority queue, one transaction at a time over a single-port slot memory.
// A remove reads the head slot, then pops it; a full insert or an empty remove goes
// straight to the response. An insert moves entries back one slot at a time, each
// move taking a registered memory read and a compare. Response valid as the
// controller returns to idle; a stalled response holds the controller until it can be loaded.
// arst_n clears head, count, state and response valid; slot memory is not reset.
module stable_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::cmd_t cmd;
	spq_pkg::sts_t sts;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	spq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
// Uses spq_pkg for the transaction structs and status codes.
module spq_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input spq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input spq_pkg::rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one transaction in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in work");

	a_no_data_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == spq_pkg::ST_FULL || rsp.status == spq_pkg::ST_EMPTY)
		|-> rsp.front_tag == '0 && rsp.front_priority == '0)
		else $error("front data on failed transaction");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == spq_pkg::ST_EMPTY |-> rsp.occupancy == '0)
		else $error("empty status with nonzero occupancy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == spq_pkg::ST_FULL
		|-> (DEPTH > 31) || (rsp.occupancy == spq_pkg::OCC_W'(DEPTH)))
		else $error("full status with occupancy below depth");

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

FILE: dv/stable_priority_queue_tb.sv
// Self-checking testbench for stable_priority_queue: random and directed inserts and removes,
// each response compared with a sorted-slot scoreboard model.
// Depends on spq_pkg and the stable_priority_queue RTL.
module stable_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ITEMS  = 1850;
	localparam int DRAIN_WAIT = 40;

	// Holds a copy of the queue contents and the responses still owed by the block.
	class queue_scoreboard;
		logic [spq_pkg::PRI_W-1:0] held_pri [spq_pkg::DEPTH_DEF];
		logic [spq_pkg::TAG_W-1:0] held_tag [spq_pkg::DEPTH_DEF];
		int unsigned               held_count;
		spq_pkg::rsp_t             owed_rsp [$];
		int                        mismatches;

		function new();
			held_count = 0;
			mismatches = 0;
		endfunction

		function void note_request(spq_pkg::req_t r);
			spq_pkg::rsp_t e;
			int            pos;
			int            k;
			e = '0;
			e.status = spq_pkg::ST_DONE;
			if (r.operation == spq_pkg::OP_INSERT) begin
				if (held_count >= spq_pkg::DEPTH_DEF) begin
					e.status = spq_pkg::ST_FULL;
				end else begin
					// goes behind every entry of equal or higher priority
					pos = 0;
					while (pos < held_count && held_pri[pos] >= r.entry_priority)
						pos++;
					for (k = held_count; k > pos; k--) begin
						held_pri[k] = held_pri[k-1];
						held_tag[k] = held_tag[k-1];
					end
					held_pri[pos] = r.entry_priority;
					held_tag[pos] = r.entry_tag;
					held_count++;
				end
			end else begin
				if (held_count == 0) begin
					e.status = spq_pkg::ST_EMPTY;
				end else begin
					e.front_priority = held_pri[0];
					e.front_tag      = held_tag[0];
					for (k = 1; k < held_count; k++) begin
						held_pri[k-1] = held_pri[k];
						held_tag[k-1] = held_tag[k];
					end
					held_count--;
				end
			end
			e.occupancy = spq_pkg::OCC_W'(held_count);
			owed_rsp.push_back(e);
		endfunction

		function void check_response(spq_pkg::rsp_t got);
			spq_pkg::rsp_t e;
			if (owed_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: response with none outstanding: ",
						"status %0d tag %h pri %h occ %0d"},
						$realtime, got.status, got.front_tag, got.front_priority,
						got.occupancy);
				return;
			end
			e = owed_rsp.pop_front();
			if (got.status !== e.status || got.front_tag !== e.front_tag ||
			    got.front_priority !== e.front_priority || got.occupancy !== e.occupancy) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch exp status %0d tag %h pri %h occ %0d, ",
						"got status %0d tag %h pri %h occ %0d"},
						$realtime, e.status, e.front_tag, e.front_priority, e.occupancy,
						got.status, got.front_tag, got.front_priority, got.occupancy);
			end
		endfunction

		function int pending();
			return owed_rsp.size();
		endfunction

		function bit failed();
			return mismatches != 0 || owed_rsp.size() != 0;
		endfunction
	endclass

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	spq_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	spq_pkg::rsp_t rsp;

	queue_scoreboard sb;
	int stall_left = 0;
	bit rx_calm    = 1'b0;
	int sent       = 0;

	stable_priority_queue #(.DEPTH(spq_pkg::DEPTH_DEF)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// response side: check accepted transactions, random stall with calm stretches
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if ($urandom_range(0, 399) == 0)
				rx_calm = !rx_calm;
			if (stall_left == 0 && !rx_calm && $urandom_range(0, 99) < 30)
				stall_left = gap_len();
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send(logic op, logic [spq_pkg::PRI_W-1:0] pri,
	                    logic [spq_pkg::TAG_W-1:0] tag);
		spq_pkg::req_t r;
		r.operation      = op;
		r.entry_priority = pri;
		r.entry_tag      = tag;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		sent++;
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		if (sb.pending() != 0) begin
			req_valid <= 1'b0;
			while (sb.pending() != 0)
				@(posedge clk);
		end
	endtask

	initial begin
		int          burst;
		int          ins_pct;
		bit          calm;
		logic        op;
		logic [7:0]  pri;
		logic [7:0]  fill_pri [9];

		fill_pri = '{8'd1, 8'd254, 8'd127, 8'd128, 8'd0, 8'd255, 8'd64, 8'd64, 8'd200};
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remove on empty, fields set but ignored
		send(spq_pkg::OP_REMOVE, 8'hFF, 16'hFFFF);
		idle(gap_len());
		// fill with extremes and equal priorities to check FIFO order among ties
		send(spq_pkg::OP_INSERT, 8'd255, 16'hFFFF);
		send(spq_pkg::OP_INSERT, 8'd0,   16'h0000);
		idle(gap_len());
		send(spq_pkg::OP_INSERT, 8'd255, 16'h0001);
		send(spq_pkg::OP_INSERT, 8'd128, 16'h1234);
		send(spq_pkg::OP_INSERT, 8'd0,   16'h0002);
		idle(gap_len());
		send(spq_pkg::OP_INSERT, 8'd128, 16'h1235);
		send(spq_pkg::OP_INSERT, 8'd255, 16'h0003);
		for (int i = 0; i < 9; i++) begin
			send(spq_pkg::OP_INSERT, fill_pri[i], 16'h0100 + 16'(i));
			idle(gap_len());
		end
		// queue full now
		send(spq_pkg::OP_INSERT, 8'd255, 16'hBEEF);
		send(spq_pkg::OP_INSERT, 8'd0,   16'h0000);
		send(spq_pkg::OP_REMOVE, 8'h00, 16'h0000);
		send(spq_pkg::OP_REMOVE, 8'hA5, 16'h5A5A);
		idle(gap_len());
		send(spq_pkg::OP_REMOVE, 8'h5A, 16'hA5A5);
		send(spq_pkg::OP_REMOVE, 8'hFF, 16'hFFFF);
		wait_for_results();

		while (sent < NUM_ITEMS) begin
			burst = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0:       ins_pct = 85;
				1:       ins_pct = 50;
				default: ins_pct = 15;
			endcase
			calm = ($urandom_range(0, 4) == 0);
			repeat (burst) begin
				op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT
				                                       : spq_pkg::OP_REMOVE;
				// few distinct priorities most of the time so ties are common
				if ($urandom_range(0, 3) == 0)
					pri = 8'($urandom_range(0, 255));
				else
					pri = 8'($urandom_range(0, 3) * 85);
				send(op, pri, 16'($urandom_range(0, 65535)));
				if (!calm)
					idle(gap_len());
			end
			if ($urandom_range(0, 7) == 0)
				wait_for_results();
		end

		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.failed())
			$display("simulation failed");
		else
			$display("simulation ok");
		$finish;
	end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
dv/stable_priority_queue_tb.sv
